FILE: rtl/svfp_pkg.sv
`default_nettype none
package svfp_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_NEW_STREAM = 2'd1,
    KIND_TABLE_FULL = 2'd2
  } result_kind_e;

  localparam logic [7:0] TAG_NOASDU   = 8'h80;  // noASDU in savPdu, svID in ASDU
  localparam logic [7:0] TAG_SEQASDU  = 8'hA2;
  localparam logic [7:0] TAG_SEQDATA  = 8'h87;
  localparam logic [7:0] LEN_LONG1    = 8'h81;
  localparam logic [7:0] LEN_LONG2    = 8'h82;
  localparam logic [7:0] LEN_LONG_MIN = 8'h80;
  localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
  localparam logic [15:0] ETYPE_SV    = 16'h88BA;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_word_t;

  // word handed from the front to the parser
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
    logic       live;       // inside the frame length limit
  } item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [3:0]         stream_index;
    logic [7:0]         asdu_index;
    logic [4:0]         channel_index;
    logic signed [31:0] sample_value;
    logic [15:0]        app_id;
    logic               has_vlan;
    logic [11:0]        vlan_id;
    logic [2:0]         vlan_priority;
    logic [7:0]         asdu_count;
    logic [47:0]        mac_destination;
    logic [47:0]        mac_source;
  } out_word_t;

endpackage
`default_nettype wire

FILE: rtl/svfp_front.sv
`default_nettype none
module svfp_front #(
  parameter int FRAME_BYTES = 2048
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire svfp_pkg::in_word_t in_word_i,
  output logic                   push_o,
  output svfp_pkg::item_t        item_o,
  input  wire logic              q_ready_i
);

  localparam int FW = $clog2(FRAME_BYTES + 1);

  logic [FW-1:0] cnt_q, cnt_d;
  logic          acc;

  assign in_ready_o = q_ready_i;
  assign acc        = in_valid_i && q_ready_i;
  assign push_o     = acc;

  always_comb begin
    item_o.data_byte  = in_word_i.data_byte;
    item_o.frame_last = in_word_i.frame_last;
    item_o.live       = (cnt_q < FW'(FRAME_BYTES));
    cnt_d = cnt_q;
    if (acc) begin
      if (in_word_i.frame_last) cnt_d = '0;
      else if (item_o.live) cnt_d = cnt_q + FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

endmodule
`default_nettype wire

FILE: rtl/svfp_queue.sv
`default_nettype none
module svfp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire svfp_pkg::item_t item_i,
  output logic                 ready_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output svfp_pkg::item_t      item_o
);

  svfp_pkg::item_t buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/svfp_back.sv
`default_nettype none
module svfp_back #(
  parameter int MAX_STREAMS = 16,
  parameter int ID_BYTES    = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire svfp_pkg::item_t q_item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output svfp_pkg::out_word_t  out_word_o
);

  localparam int SW = $clog2(MAX_STREAMS + 1);
  localparam int CW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int IW = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;

  typedef enum logic [3:0] {
    PH_MAC, PH_TYPE, PH_TCI, PH_HDR, PH_PDU_TAG, PH_LEN, PH_PDU_FTAG, PH_NOASDU,
    PH_ASDU_TAG, PH_AFTAG, PH_SVID, PH_SEQ, PH_SKIP, PH_IDLE
  } phase_e;

  typedef enum logic [1:0] {CTX_PDU, CTX_PDU_FIELD, CTX_ASDU, CTX_ASDU_FIELD} ctx_e;

  phase_e           ph_q, ph_d;
  ctx_e             ctx_q, ctx_d;
  logic [3:0]       bp_q, bp_d;
  logic [15:0]      fr_q, fr_d, ar_q, ar_d;
  logic             vlan_q, vlan_d, in_asdu_q, in_asdu_d, sv_q, sv_d;
  logic [15:0]      app_q, app_d;
  logic [11:0]      vid_q, vid_d;
  logic [2:0]       prio_q, prio_d;
  logic [47:0]      dst_q, dst_d, src_q, src_d;
  logic [7:0]       total_q, total_d, seen_q, seen_d, idb_q, idb_d;
  logic [7:0]       tag_q, tag_d, svlen_q, svlen_d;
  logic [1:0]       more_q, more_d;
  logic [MAX_STREAMS-1:0] mv_q, mv_d, mism;
  logic [CW-1:0]    cur_q, cur_d;
  logic [SW-1:0]    scnt_q, scnt_d;
  logic [23:0]      sh_q, sh_d;
  logic [4:0]       ch_q, ch_d;

  logic [7:0]       idlen_q [MAX_STREAMS];
  logic [7:0]       rd_q [MAX_STREAMS];
  logic             id_we, len_we;
  logic             go, emit;
  svfp_pkg::out_word_t ow, out_q;
  logic             out_valid_q;

  assign go          = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = go;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    for (int e = 0; e < MAX_STREAMS; e++) begin
      mism[e] = (SW'(e) < scnt_q) && (rd_q[e] != q_item_i.data_byte);
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic        ld, fin, fd;
    logic [15:0] len, v;
    b   = q_item_i.data_byte;
    ld  = 1'b0;
    fin = 1'b0;
    fd  = 1'b0;
    len = '0;
    v   = '0;
    ph_d = ph_q; ctx_d = ctx_q; bp_d = bp_q; fr_d = fr_q; ar_d = ar_q;
    vlan_d = vlan_q; in_asdu_d = in_asdu_q; sv_d = sv_q; app_d = app_q;
    vid_d = vid_q; prio_d = prio_q; dst_d = dst_q; src_d = src_q;
    total_d = total_q; seen_d = seen_q; idb_d = idb_q; tag_d = tag_q;
    svlen_d = svlen_q; more_d = more_q; mv_d = mv_q; cur_d = cur_q;
    scnt_d = scnt_q; sh_d = sh_q; ch_d = ch_q;
    id_we = 1'b0; len_we = 1'b0; emit = 1'b0;
    ow = '0;

    if (go && q_item_i.live) begin
      if (in_asdu_q && ar_q != 16'd0) ar_d = ar_q - 16'd1;
      unique case (ph_q)
        PH_MAC: begin
          if (bp_q < 4'd6) dst_d = {dst_q[39:0], b};
          else src_d = {src_q[39:0], b};
          bp_d = bp_q + 4'd1;
          if (bp_d >= 4'd12) begin
            bp_d = '0;
            ph_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (bp_q == 4'd0) begin
            sh_d = {16'd0, b};
            bp_d = 4'd1;
          end else begin
            v = {sh_q[7:0], b};
            bp_d = '0;
            if (v == svfp_pkg::ETYPE_VLAN && !vlan_q) begin
              vlan_d = 1'b1;
              ph_d = PH_TCI;
            end else if (v == svfp_pkg::ETYPE_SV) ph_d = PH_HDR;
            else ph_d = PH_IDLE;
          end
        end
        PH_TCI: begin
          if (bp_q == 4'd0) begin
            prio_d = b[7:5];
            vid_d  = {b[3:0], 8'd0};
            bp_d   = 4'd1;
          end else begin
            vid_d = vid_q | {4'd0, b};
            bp_d  = '0;
            ph_d  = PH_TYPE;
          end
        end
        PH_HDR: begin
          if (bp_q < 4'd2) app_d = {app_q[7:0], b};
          bp_d = bp_q + 4'd1;
          if (bp_d >= 4'd8) begin
            bp_d = '0;
            ph_d = PH_PDU_TAG;
          end
        end
        PH_PDU_TAG, PH_PDU_FTAG, PH_ASDU_TAG, PH_AFTAG: begin
          unique case (ph_q)
            PH_PDU_TAG:  ctx_d = CTX_PDU;
            PH_PDU_FTAG: ctx_d = CTX_PDU_FIELD;
            PH_ASDU_TAG: ctx_d = CTX_ASDU;
            default:     ctx_d = CTX_ASDU_FIELD;
          endcase
          tag_d  = b;
          more_d = '0;
          ph_d   = PH_LEN;
        end
        PH_LEN: begin
          if (more_q == 2'd0) begin
            if (b < svfp_pkg::LEN_LONG_MIN) begin
              ld  = 1'b1;
              len = {8'd0, b};
            end else if (b == svfp_pkg::LEN_LONG1 || b == svfp_pkg::LEN_LONG2) begin
              more_d = b[1:0];
              fr_d   = '0;
            end else ph_d = PH_IDLE;
          end else begin
            fr_d   = {fr_q[7:0], b};
            more_d = more_q - 2'd1;
            if (more_d == 2'd0) begin
              ld  = 1'b1;
              len = fr_d;
            end
          end
        end
        PH_NOASDU: begin
          total_d = b;
          fr_d = fr_q - 16'd1;
          if (fr_d == 16'd0) ph_d = PH_PDU_FTAG;
        end
        PH_SVID: begin
          if (idb_q < 8'(ID_BYTES)) begin
            mv_d = mv_q & ~mism;
            id_we = (scnt_q < SW'(MAX_STREAMS));
          end
          if (idb_q != 8'd255) idb_d = idb_q + 8'd1;
          fr_d = fr_q - 16'd1;
          if (fr_d == 16'd0) fin = 1'b1;
        end
        PH_SEQ: begin
          if (bp_q < 4'd3) sh_d = {sh_q[15:0], b};
          else if (bp_q == 4'd3) begin
            emit = 1'b1;
            ow.result_kind   = svfp_pkg::KIND_SAMPLE;
            ow.stream_index  = 4'(cur_q);
            ow.channel_index = ch_q;
            ow.sample_value  = {sh_q, b};
            ch_d = ch_q + 5'd1;
            sh_d = '0;
          end
          bp_d = {1'b0, bp_q[2:0] + 3'd1};
          fr_d = fr_q - 16'd1;
          if (fr_d == 16'd0) fd = 1'b1;
        end
        PH_SKIP: begin
          fr_d = fr_q - 16'd1;
          if (fr_d == 16'd0) fd = 1'b1;
        end
        default: ;
      endcase

      // length complete: dispatch on context and tag
      if (ld) begin
        unique case (ctx_q)
          CTX_PDU: ph_d = PH_PDU_FTAG;
          CTX_PDU_FIELD: begin
            if (tag_q == svfp_pkg::TAG_NOASDU) begin
              total_d = '0;
              if (len == 16'd0) ph_d = PH_PDU_FTAG;
              else begin
                fr_d = len;
                ph_d = PH_NOASDU;
              end
            end else if (tag_q == svfp_pkg::TAG_SEQASDU) begin
              seen_d = '0;
              ph_d = (total_d == 8'd0) ? PH_IDLE : PH_ASDU_TAG;
            end else if (len == 16'd0) fd = 1'b1;
            else begin
              fr_d = len;
              ph_d = PH_SKIP;
            end
          end
          CTX_ASDU: begin
            in_asdu_d = 1'b1;
            ar_d = len;
            sv_d = 1'b0;
            fd = 1'b1;
          end
          default: begin
            if (tag_q == svfp_pkg::TAG_NOASDU) begin
              svlen_d = (len > 16'd255) ? 8'd255 : len[7:0];
              for (int e = 0; e < MAX_STREAMS; e++) begin
                mv_d[e] = (SW'(e) < scnt_q) && (idlen_q[e] == svlen_d);
              end
              idb_d = '0;
              if (len == 16'd0) fin = 1'b1;
              else begin
                fr_d = len;
                ph_d = PH_SVID;
              end
            end else if (tag_q == svfp_pkg::TAG_SEQDATA && sv_q && len != 16'd0) begin
              fr_d = len;
              bp_d = '0;
              ch_d = '0;
              sh_d = '0;
              ph_d = PH_SEQ;
            end else if (len == 16'd0) fd = 1'b1;
            else begin
              fr_d = len;
              ph_d = PH_SKIP;
            end
          end
        endcase
      end

      // svID complete: match, register or drop
      if (fin) begin
        if (mv_d != '0) begin
          for (int e = MAX_STREAMS - 1; e >= 0; e--) begin
            if (mv_d[e]) cur_d = CW'(e);
          end
          sv_d = 1'b1;
          fd = 1'b1;
        end else if (scnt_q < SW'(MAX_STREAMS)) begin
          len_we = 1'b1;
          cur_d  = CW'(scnt_q);
          sv_d   = 1'b1;
          scnt_d = scnt_q + SW'(1);
          emit   = 1'b1;
          ow.result_kind  = svfp_pkg::KIND_NEW_STREAM;
          ow.stream_index = 4'(scnt_q);
          fd = 1'b1;
        end else begin
          emit = 1'b1;
          ow.result_kind = svfp_pkg::KIND_TABLE_FULL;
          ph_d = PH_IDLE;
        end
      end

      // field complete
      if (fd) begin
        if (in_asdu_d) begin
          if (ar_d == 16'd0) begin
            in_asdu_d = 1'b0;
            seen_d = seen_d + 8'd1;
            ph_d = (seen_d >= total_d) ? PH_IDLE : PH_ASDU_TAG;
          end else ph_d = PH_AFTAG;
        end else ph_d = PH_PDU_FTAG;
      end
    end

    ow.asdu_index      = seen_d;
    ow.app_id          = app_d;
    ow.has_vlan        = vlan_d;
    ow.vlan_id         = vid_d;
    ow.vlan_priority   = prio_d;
    ow.asdu_count      = total_d;
    ow.mac_destination = dst_d;
    ow.mac_source      = src_d;

    if (go && q_item_i.frame_last) begin
      ph_d = PH_MAC; bp_d = '0; fr_d = '0; vlan_d = 1'b0; app_d = '0; vid_d = '0;
      prio_d = '0; dst_d = '0; src_d = '0; total_d = '0; seen_d = '0; idb_d = '0;
      mv_d = '0; cur_d = '0; sv_d = 1'b0; sh_d = '0; ch_d = '0; ar_d = '0;
      in_asdu_d = 1'b0; tag_d = '0; ctx_d = CTX_PDU; more_d = '0; svlen_d = '0;
    end
  end

  // per-stream ID memories, read one byte ahead of the compare
  for (genvar g = 0; g < MAX_STREAMS; g++) begin : g_id
    logic [7:0] mem [ID_BYTES];
    always_ff @(posedge clk_i) begin
      if (id_we && scnt_q == SW'(g)) mem[idb_q[IW-1:0]] <= q_item_i.data_byte;
      rd_q[g] <= mem[idb_d[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) idlen_q[scnt_q[CW-1:0]] <= svlen_d;
    if (go && emit) out_q <= ow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_MAC; ctx_q <= CTX_PDU; bp_q <= '0; fr_q <= '0; ar_q <= '0;
      vlan_q <= 1'b0; in_asdu_q <= 1'b0; sv_q <= 1'b0; app_q <= '0; vid_q <= '0;
      prio_q <= '0; dst_q <= '0; src_q <= '0; total_q <= '0; seen_q <= '0;
      idb_q <= '0; tag_q <= '0; svlen_q <= '0; more_q <= '0; mv_q <= '0;
      cur_q <= '0; scnt_q <= '0; sh_q <= '0; ch_q <= '0; out_valid_q <= 1'b0;
    end else begin
      ph_q <= ph_d; ctx_q <= ctx_d; bp_q <= bp_d; fr_q <= fr_d; ar_q <= ar_d;
      vlan_q <= vlan_d; in_asdu_q <= in_asdu_d; sv_q <= sv_d; app_q <= app_d;
      vid_q <= vid_d; prio_q <= prio_d; dst_q <= dst_d; src_q <= src_d;
      total_q <= total_d; seen_q <= seen_d; idb_q <= idb_d; tag_q <= tag_d;
      svlen_q <= svlen_d; more_q <= more_d; mv_q <= mv_d; cur_q <= cur_d;
      scnt_q <= scnt_d; sh_q <= sh_d; ch_q <= ch_d;
      if (go && emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sampled_values_frame_parser.sv
// A result word follows the byte that causes it through the queue, the
// parser and the output register. Throughput: one byte per cycle, set by
// the single parser pass per byte; the parser holds only while the output
// register is full and not taken. Reset (rst_ni low, async) empties the
// queue and output and clears the stream table count; ID bytes need no clear.
`default_nettype none
module sampled_values_frame_parser #(
  parameter int MAX_STREAMS = 16,
  parameter int ID_BYTES    = 64,
  parameter int FRAME_BYTES = 2048
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire svfp_pkg::in_word_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output svfp_pkg::out_word_t     out_word_o
);

  // front: per-frame byte count, marks bytes past the frame limit
  logic            push, q_ready, q_valid, pop;
  svfp_pkg::item_t push_item, q_item;

  svfp_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_word_i,
    .push_o(push), .item_o(push_item), .q_ready_i(q_ready)
  );

  // two-word queue decouples input from parser stalls
  svfp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .item_i(push_item), .ready_o(q_ready),
    .pop_i(pop), .valid_o(q_valid), .item_o(q_item)
  );

  // back: header/BER walk, svID lookup, sample extraction, output register
  svfp_back #(.MAX_STREAMS(MAX_STREAMS), .ID_BYTES(ID_BYTES)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_item_i(q_item), .pop_o(pop),
    .out_valid_o, .out_ready_i, .out_word_o
  );

endmodule
`default_nettype wire
